// ----- rtl/core/ahd_pkg.sv -----
// ----------------------------------------------------------------------------
// ahd_pkg: shared types and constants of the AX.25 header decoder
// Frame offsets, control field codes, result codes and the queue entry type.
// ----------------------------------------------------------------------------
package ahd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 12;
  localparam int CFG_BITS            = 12;
  localparam int PADDR_BITS          = 3;
  localparam int PDATA_BITS          = 32;

  localparam logic [CFG_BITS-1:0] MIN_LENGTH_RESET = 12'd15;
  localparam logic [CFG_BITS-1:0] MAX_LENGTH_RESET = 12'd2100;

  // register select bit (paddr[2])
  localparam logic REG_MIN_LENGTH = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  // byte offsets within the frame
  localparam int ADDR_CHARS    = 6;
  localparam int POS_DEST_SSID = 6;
  localparam int POS_SRC_SSID  = 13;
  localparam int POS_CONTROL   = 14;
  localparam int POS_PID       = 15;
  localparam int HEADER_BYTES  = 15;

  // control field codes (P/F masked)
  localparam logic [7:0] CTL_PF_MASK = 8'hef;
  localparam logic [7:0] CTL_SABM    = 8'h2f;
  localparam logic [7:0] CTL_DISC    = 8'h43;
  localparam logic [7:0] CTL_DM      = 8'h0f;
  localparam logic [7:0] CTL_UA      = 8'h63;
  localparam logic [7:0] CTL_FRMR    = 8'h87;
  localparam logic [7:0] CTL_UI      = 8'h03;
  localparam logic [7:0] CTL_UI_PF   = 8'h13;
  localparam logic [7:0] PID_ESCAPE  = 8'hff;

  // frame_kind codes
  localparam logic [3:0] KIND_I     = 4'd0;
  localparam logic [3:0] KIND_RR    = 4'd1;
  localparam logic [3:0] KIND_SREJ  = 4'd4;
  localparam logic [3:0] KIND_SABM  = 4'd5;
  localparam logic [3:0] KIND_DISC  = 4'd6;
  localparam logic [3:0] KIND_DM    = 4'd7;
  localparam logic [3:0] KIND_UA    = 4'd8;
  localparam logic [3:0] KIND_FRMR  = 4'd9;
  localparam logic [3:0] KIND_UI    = 4'd10;
  localparam logic [3:0] KIND_OTHER = 4'd11;
  localparam logic [3:0] KIND_BAD   = 4'd12;

  // cmd_res codes
  localparam logic [1:0] CR_COMMAND  = 2'd0;
  localparam logic [1:0] CR_RESPONSE = 2'd1;
  localparam logic [1:0] CR_BOTH     = 2'd2;
  localparam logic [1:0] CR_NEITHER  = 2'd3;

  // result_kind codes
  localparam logic RESULT_CHAR    = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;

  // one classified byte, as handed from front to back
  typedef struct packed {
    logic        has_char;
    logic [6:0]  addr_char;
    logic [3:0]  char_index;
    logic        is_last;
    logic        bad;
    logic [11:0] info_length;
    logic [7:0]  control;
    logic [7:0]  pid;
    logic [7:0]  dest_ssid_byte;
    logic [7:0]  src_ssid_byte;
  } entry_t;

  function automatic logic [3:0] decode_kind(input logic [7:0] c);
    logic [3:0] kind;
    kind = KIND_OTHER;
    priority if (!c[0]) begin
      kind = KIND_I;
    end else if (!c[1]) begin
      kind = KIND_RR + 4'(c[3:2]);
    end else begin
      unique case (c & CTL_PF_MASK)
        CTL_SABM: kind = KIND_SABM;
        CTL_DISC: kind = KIND_DISC;
        CTL_DM:   kind = KIND_DM;
        CTL_UA:   kind = KIND_UA;
        CTL_FRMR: kind = KIND_FRMR;
        CTL_UI:   kind = KIND_UI;
        default:  kind = KIND_OTHER;
      endcase
    end
    return kind;
  endfunction

endpackage

// ----- rtl/core/ax25_header_decoder.sv -----
// ----------------------------------------------------------------------------
// ax25_header_decoder: AX.25 frame header decoder
// Decodes address characters and an end-of-frame summary from a byte stream.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  --------------------------------------
//  byte      byte_valid / byte_ready    data_byte, last_byte
//  result    result_valid / result_ready result_kind .. src_ssid (12 fields)
//  config    APB psel/penable/pready    paddr, pwdata, prdata (min/max length)
//
//  Takes one byte per cycle while byte_ready is high. Each byte is classified
//  in the front end in the cycle it is accepted; results leave through a
//  single output register, one item per cycle while result_ready is high,
//  each registered first in the queue and then in the output register.
//  A final byte that is also an address character gives two items; the
//  four-entry queue absorbs that and any downstream stall before byte_ready drops.
//  Synchronous reset clears the frame position, the header captures and the
//  queue, and loads min_length = 15 and max_length = 2100.
//
//  Registers: min_length at byte address 0, max_length at byte address 4.
// ----------------------------------------------------------------------------
module ax25_header_decoder #(
  parameter int LENGTH_BITS = ahd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // byte channel
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            result_kind,
  output logic [6:0]                      addr_char,
  output logic [3:0]                      char_index,
  output logic [3:0]                      frame_kind,
  output logic [1:0]                      cmd_res,
  output logic                            poll_final,
  output logic [2:0]                      recv_seq,
  output logic [2:0]                      send_seq,
  output logic [7:0]                      pid_value,
  output logic [11:0]                     info_length,
  output logic [3:0]                      dest_ssid,
  output logic [3:0]                      src_ssid,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ahd_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [ahd_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [ahd_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready
);

  logic [ahd_pkg::CFG_BITS-1:0] min_length;
  logic [ahd_pkg::CFG_BITS-1:0] max_length;
  logic                         cfg_write;

  logic                         push_valid;
  logic                         push_ready;
  ahd_pkg::entry_t              push_entry;
  logic                         pop_valid;
  logic                         pop_ready;
  ahd_pkg::entry_t              pop_entry;

  // Configuration: write in the access phase, word select on paddr[2].
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= ahd_pkg::MIN_LENGTH_RESET;
      max_length <= ahd_pkg::MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        ahd_pkg::REG_MIN_LENGTH: min_length <= pwdata[ahd_pkg::CFG_BITS-1:0];
        ahd_pkg::REG_MAX_LENGTH: max_length <= pwdata[ahd_pkg::CFG_BITS-1:0];
      endcase
    end
  end

  // Read back the selected bound, zero-extended.
  assign prdata = (paddr[2] == ahd_pkg::REG_MAX_LENGTH) ?
                  ahd_pkg::PDATA_BITS'(max_length) : ahd_pkg::PDATA_BITS'(min_length);

  // Front end: count bytes, capture header fields, classify.
  ahd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .min_length (min_length),
    .max_length (max_length),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decouple intake from result delivery.
  ahd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // Back end: expand entries into items and hold them in the output register.
  ahd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_entry    (pop_entry),
    .pop_ready    (pop_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .addr_char    (addr_char),
    .char_index   (char_index),
    .frame_kind   (frame_kind),
    .cmd_res      (cmd_res),
    .poll_final   (poll_final),
    .recv_seq     (recv_seq),
    .send_seq     (send_seq),
    .pid_value    (pid_value),
    .info_length  (info_length),
    .dest_ssid    (dest_ssid),
    .src_ssid     (src_ssid)
  );

`ifndef SYNTHESIS
  // A bad frame summary carries nothing but its kind.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == ahd_pkg::RESULT_SUMMARY) &&
    (frame_kind == ahd_pkg::KIND_BAD) |->
    (cmd_res == ahd_pkg::CR_COMMAND) && !poll_final && (info_length == '0) &&
    (pid_value == '0) && (dest_ssid == '0) && (src_ssid == '0))
    else $error("bad frame summary carries data");

  // A character item has a valid index and no summary fields.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == ahd_pkg::RESULT_CHAR) |->
    (char_index <= 4'd11) && (frame_kind == ahd_pkg::KIND_I) && (info_length == '0))
    else $error("character item malformed");

  // N(S) appears only on I frames.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == ahd_pkg::RESULT_SUMMARY) &&
    (frame_kind != ahd_pkg::KIND_I) |-> (send_seq == '0))
    else $error("send sequence on non-I frame");

  // The queue never drops an entry the front end offered.
  assert property (@(posedge clk) disable iff (rst)
    push_valid && !push_ready |-> !byte_ready)
    else $error("entry offered while byte accepted");
`endif

endmodule

// ----- rtl/core/ahd_front.sv -----
// ----------------------------------------------------------------------------
// ahd_front: byte intake and classification
// Tracks the frame position, captures header bytes and queues one entry per
// byte that produces a result.
// ----------------------------------------------------------------------------
module ahd_front #(
  parameter int LENGTH_BITS = ahd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [ahd_pkg::CFG_BITS-1:0]  min_length,
  input  logic [ahd_pkg::CFG_BITS-1:0]  max_length,
  output logic                          push_valid,
  output ahd_pkg::entry_t               push_entry,
  input  logic                          push_ready
);

  localparam int LW = LENGTH_BITS + 1;
  localparam int DW = (LW > ahd_pkg::CFG_BITS) ? LW : ahd_pkg::CFG_BITS;
  localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

  logic [LENGTH_BITS-1:0] byte_position;
  logic [7:0]             control_byte;
  logic [7:0]             pid_byte;
  logic [7:0]             dest_ssid_byte;
  logic [7:0]             src_ssid_byte;
  logic                   overflow_flag;

  logic                   accept;
  logic                   in_dest;
  logic                   in_src;
  logic [7:0]             control_now;
  logic [7:0]             pid_now;
  logic [7:0]             dest_now;
  logic [7:0]             src_now;
  logic [DW-1:0]          length_now;
  logic [DW-1:0]          used_len;
  logic [DW-1:0]          info_full;
  logic                   has_pid;
  logic [1:0]             pid_count;
  logic                   bad;

  assign byte_ready = push_ready;
  assign accept     = byte_valid && push_ready;

  assign in_dest = byte_position < LENGTH_BITS'(ahd_pkg::ADDR_CHARS);
  assign in_src  = (byte_position > LENGTH_BITS'(ahd_pkg::POS_DEST_SSID)) &&
                   (byte_position < LENGTH_BITS'(ahd_pkg::POS_SRC_SSID));

  // header bytes as they stand after this byte
  assign control_now = (byte_position == LENGTH_BITS'(ahd_pkg::POS_CONTROL)) ?
                       data_byte : control_byte;
  assign pid_now     = (byte_position == LENGTH_BITS'(ahd_pkg::POS_PID)) ?
                       data_byte : pid_byte;
  assign dest_now    = (byte_position == LENGTH_BITS'(ahd_pkg::POS_DEST_SSID)) ?
                       data_byte : dest_ssid_byte;
  assign src_now     = (byte_position == LENGTH_BITS'(ahd_pkg::POS_SRC_SSID)) ?
                       data_byte : src_ssid_byte;

  assign length_now = DW'(byte_position) + DW'(1);

  assign bad = overflow_flag || (byte_position == POS_MAX) ||
               (length_now < DW'(min_length)) || (length_now > DW'(max_length));

  assign has_pid   = !control_now[0] || (control_now == ahd_pkg::CTL_UI) ||
                     (control_now == ahd_pkg::CTL_UI_PF);
  assign pid_count = !has_pid ? 2'd0 : ((pid_now == ahd_pkg::PID_ESCAPE) ? 2'd2 : 2'd1);
  assign used_len  = DW'(ahd_pkg::HEADER_BYTES) + DW'(pid_count);
  assign info_full = (length_now > used_len) ? (length_now - used_len) : '0;

  always_comb begin
    push_entry                = '0;
    push_entry.has_char       = in_dest || in_src;
    push_entry.addr_char      = data_byte[7:1];
    push_entry.char_index     = in_dest ? 4'(byte_position) : 4'(byte_position - 1'b1);
    push_entry.is_last        = last_byte;
    push_entry.bad            = bad;
    push_entry.info_length    = info_full[ahd_pkg::CFG_BITS-1:0];
    push_entry.control        = control_now;
    push_entry.pid            = pid_now;
    push_entry.dest_ssid_byte = dest_now;
    push_entry.src_ssid_byte  = src_now;
  end

  assign push_valid = byte_valid && (in_dest || in_src || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      control_byte   <= '0;
      pid_byte       <= '0;
      dest_ssid_byte <= '0;
      src_ssid_byte  <= '0;
      overflow_flag  <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position  <= '0;
        control_byte   <= '0;
        pid_byte       <= '0;
        dest_ssid_byte <= '0;
        src_ssid_byte  <= '0;
        overflow_flag  <= 1'b0;
      end else begin
        control_byte   <= control_now;
        pid_byte       <= pid_now;
        dest_ssid_byte <= dest_now;
        src_ssid_byte  <= src_now;
        if (byte_position == POS_MAX) begin
          overflow_flag <= 1'b1;
        end else begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/ahd_queue.sv -----
// ----------------------------------------------------------------------------
// ahd_queue: short entry queue between front and back
// Four entries, first in first out, push and pop in the same cycle.
// ----------------------------------------------------------------------------
module ahd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  ahd_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            pop_valid,
  output ahd_pkg::entry_t pop_entry,
  input  logic            pop_ready
);

  ahd_pkg::entry_t                    slots [ahd_pkg::QUEUE_DEPTH];
  logic [ahd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [ahd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [ahd_pkg::QUEUE_PTR_BITS:0]   count;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = count != (ahd_pkg::QUEUE_PTR_BITS+1)'(ahd_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/ahd_back.sv -----
// ----------------------------------------------------------------------------
// ahd_back: result generation and output register
// Turns queued entries into character and summary results, one per cycle unless result_ready stalls the output.
// ----------------------------------------------------------------------------
module ahd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  input  ahd_pkg::entry_t pop_entry,
  output logic            pop_ready,
  output logic            result_valid,
  input  logic            result_ready,
  output logic            result_kind,
  output logic [6:0]      addr_char,
  output logic [3:0]      char_index,
  output logic [3:0]      frame_kind,
  output logic [1:0]      cmd_res,
  output logic            poll_final,
  output logic [2:0]      recv_seq,
  output logic [2:0]      send_seq,
  output logic [7:0]      pid_value,
  output logic [11:0]     info_length,
  output logic [3:0]      dest_ssid,
  output logic [3:0]      src_ssid
);

  logic       char_sent;
  logic       load;
  logic       emit_char;
  logic [3:0] kind;
  logic       dest_c;
  logic       src_c;
  logic [1:0] cr_code;

  assign load      = pop_valid && (!result_valid || result_ready);
  assign emit_char = pop_entry.has_char && !char_sent;
  // a final byte that is also a character keeps its entry for the summary
  assign pop_ready = load && !(emit_char && pop_entry.is_last);

  assign kind   = ahd_pkg::decode_kind(pop_entry.control);
  assign dest_c = pop_entry.dest_ssid_byte[7];
  assign src_c  = pop_entry.src_ssid_byte[7];

  always_comb begin
    unique case ({dest_c, src_c})
      2'b11:   cr_code = ahd_pkg::CR_BOTH;
      2'b10:   cr_code = ahd_pkg::CR_COMMAND;
      2'b01:   cr_code = ahd_pkg::CR_RESPONSE;
      default: cr_code = ahd_pkg::CR_NEITHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      char_sent    <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        char_sent    <= emit_char && pop_entry.is_last;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= ahd_pkg::RESULT_CHAR;
      addr_char   <= '0;
      char_index  <= '0;
      frame_kind  <= ahd_pkg::KIND_I;
      cmd_res     <= ahd_pkg::CR_COMMAND;
      poll_final  <= 1'b0;
      recv_seq    <= '0;
      send_seq    <= '0;
      pid_value   <= '0;
      info_length <= '0;
      dest_ssid   <= '0;
      src_ssid    <= '0;
      if (emit_char) begin
        addr_char  <= pop_entry.addr_char;
        char_index <= pop_entry.char_index;
      end else begin
        result_kind <= ahd_pkg::RESULT_SUMMARY;
        if (pop_entry.bad) begin
          frame_kind <= ahd_pkg::KIND_BAD;
        end else begin
          frame_kind  <= kind;
          cmd_res     <= cr_code;
          poll_final  <= pop_entry.control[4];
          recv_seq    <= (kind <= ahd_pkg::KIND_SREJ) ? pop_entry.control[7:5] : 3'd0;
          send_seq    <= (kind == ahd_pkg::KIND_I) ? pop_entry.control[3:1] : 3'd0;
          pid_value   <= pop_entry.pid;
          info_length <= pop_entry.info_length;
          dest_ssid   <= pop_entry.dest_ssid_byte[4:1];
          src_ssid    <= pop_entry.src_ssid_byte[4:1];
        end
      end
    end
  end

endmodule

// ----- dv/ax25_header_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the AX.25 header decoder
// Streams whole frames into the byte channel, predicts the address characters
// and end-of-frame summaries in a local decoder, and checks every result item
// in order across several length-bound settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 12;     // covers bytes still in flight that give no item
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, fills the decoder
  localparam int CYCLE_LIMIT  = 250000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [ahd_pkg::PADDR_BITS-1:0] ADDR_MIN_LENGTH =
    {ahd_pkg::REG_MIN_LENGTH, 2'b00};
  localparam logic [ahd_pkg::PADDR_BITS-1:0] ADDR_MAX_LENGTH =
    {ahd_pkg::REG_MAX_LENGTH, 2'b00};

  // one byte of a frame as offered on the byte channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // one result item, field for field as the ports show it
  typedef struct packed {
    logic        result_kind;
    logic [6:0]  addr_char;
    logic [3:0]  char_index;
    logic [3:0]  frame_kind;
    logic [1:0]  cmd_res;
    logic        poll_final;
    logic [2:0]  recv_seq;
    logic [2:0]  send_seq;
    logic [7:0]  pid_value;
    logic [11:0] info_length;
    logic [3:0]  dest_ssid;
    logic [3:0]  src_ssid;
  } result_t;

  // DUT signals
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic [7:0]                     data_byte = '0;
  logic                           last_byte = 1'b0;
  logic                           byte_valid = 1'b0;
  logic                           byte_ready;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  logic                           result_kind;
  logic [6:0]                     addr_char;
  logic [3:0]                     char_index;
  logic [3:0]                     frame_kind;
  logic [1:0]                     cmd_res;
  logic                           poll_final;
  logic [2:0]                     recv_seq;
  logic [2:0]                     send_seq;
  logic [7:0]                     pid_value;
  logic [11:0]                    info_length;
  logic [3:0]                     dest_ssid;
  logic [3:0]                     src_ssid;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [ahd_pkg::PADDR_BITS-1:0] paddr = '0;
  logic [ahd_pkg::PDATA_BITS-1:0] pwdata = '0;
  logic [ahd_pkg::PDATA_BITS-1:0] prdata;
  logic                           pready;

  // frame bytes waiting for the driver, and decoded items waiting for the DUT
  frame_byte_t pending_bytes[$];
  result_t     expected_results[$];

  // local decoder state, mirrors the block's frame captures
  logic [11:0] frame_pos = '0;
  logic [7:0]  ctl_seen = '0;
  logic [7:0]  pid_seen = '0;
  logic [7:0]  dest_ssid_seen = '0;
  logic [7:0]  src_ssid_seen = '0;
  logic        pos_saturated = 1'b0;
  logic [11:0] cfg_min_length = ahd_pkg::MIN_LENGTH_RESET;
  logic [11:0] cfg_max_length = ahd_pkg::MAX_LENGTH_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_arm = 1'b0;
  int hold_left = 0;
  int failures = 0;
  int cycle_count = 0;

  ax25_header_decoder uut (.*);

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local decoder
  // --------------------------------------------------------------------------

  // Classify the control field; the P/F bit (bit 4) is a don't-care for U frames.
  function automatic logic [3:0] control_kind(input logic [7:0] c);
    logic [3:0] kind;
    casez (c)
      8'b???????0: kind = ahd_pkg::KIND_I;
      8'b??????01: kind = ahd_pkg::KIND_RR + {2'b00, c[3:2]};
      8'b001?1111: kind = ahd_pkg::KIND_SABM;
      8'b010?0011: kind = ahd_pkg::KIND_DISC;
      8'b000?1111: kind = ahd_pkg::KIND_DM;
      8'b011?0011: kind = ahd_pkg::KIND_UA;
      8'b100?0111: kind = ahd_pkg::KIND_FRMR;
      8'b000?0011: kind = ahd_pkg::KIND_UI;
      default:     kind = ahd_pkg::KIND_OTHER;
    endcase
    return kind;
  endfunction

  // Build the end-of-frame summary from the captured header bytes.
  function automatic result_t frame_summary(input int length);
    result_t s;
    logic [3:0] kind;
    int used;
    s = '0;
    s.result_kind = ahd_pkg::RESULT_SUMMARY;
    // out-of-bounds or overflowed frames report only the bad type
    if (pos_saturated || length < int'(cfg_min_length) || length > int'(cfg_max_length)) begin
      s.frame_kind = ahd_pkg::KIND_BAD;
      return s;
    end
    kind = control_kind(ctl_seen);
    s.frame_kind = kind;
    // C bits sit in bit 7 of each SSID byte
    case ({dest_ssid_seen[7], src_ssid_seen[7]})
      2'b10:   s.cmd_res = ahd_pkg::CR_COMMAND;
      2'b01:   s.cmd_res = ahd_pkg::CR_RESPONSE;
      2'b11:   s.cmd_res = ahd_pkg::CR_BOTH;
      default: s.cmd_res = ahd_pkg::CR_NEITHER;
    endcase
    s.poll_final = ctl_seen[4];
    if (kind <= ahd_pkg::KIND_SREJ) s.recv_seq = ctl_seen[7:5];
    if (kind == ahd_pkg::KIND_I) s.send_seq = ctl_seen[3:1];
    s.pid_value = pid_seen;
    // only I and UI frames carry a PID; the escape value means a second PID byte
    used = ahd_pkg::HEADER_BYTES;
    if (!ctl_seen[0] || ctl_seen == ahd_pkg::CTL_UI || ctl_seen == ahd_pkg::CTL_UI_PF) begin
      used = used + ((pid_seen == ahd_pkg::PID_ESCAPE) ? 2 : 1);
    end
    s.info_length = (length > used) ? 12'(length - used) : 12'd0;
    s.dest_ssid = dest_ssid_seen[4:1];
    s.src_ssid = src_ssid_seen[4:1];
    return s;
  endfunction

  // Advance the local decoder by one accepted byte and queue the items it gives.
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    result_t r;
    int p;
    p = int'(frame_pos);
    if (p < ahd_pkg::ADDR_CHARS ||
        (p > ahd_pkg::POS_DEST_SSID && p < ahd_pkg::POS_SRC_SSID)) begin
      r = '0;
      r.result_kind = ahd_pkg::RESULT_CHAR;
      r.addr_char = b[7:1];
      // skip the destination SSID slot when numbering source characters
      r.char_index = (p < ahd_pkg::ADDR_CHARS) ? 4'(p) : 4'(p - 1);
      expected_results.push_back(r);
    end else if (p == ahd_pkg::POS_DEST_SSID) begin
      dest_ssid_seen = b;
    end else if (p == ahd_pkg::POS_SRC_SSID) begin
      src_ssid_seen = b;
    end else if (p == ahd_pkg::POS_CONTROL) begin
      ctl_seen = b;
    end else if (p == ahd_pkg::POS_PID) begin
      pid_seen = b;
    end
    // hold the position at its top value once the counter runs out
    if (frame_pos == '1) pos_saturated = 1'b1;
    else frame_pos = frame_pos + 12'd1;
    if (last) begin
      expected_results.push_back(frame_summary(p + 1));
      frame_pos = '0;
      ctl_seen = '0;
      pid_seen = '0;
      dest_ssid_seen = '0;
      src_ssid_seen = '0;
      pos_saturated = 1'b0;
    end
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf({"kind=%0d char=%02h idx=%0d type=%0d cr=%0d pf=%0d nr=%0d ns=%0d ",
                      "pid=%02h info=%0d dssid=%0d sssid=%0d"},
                     r.result_kind, r.addr_char, r.char_index, r.frame_kind, r.cmd_res,
                     r.poll_final, r.recv_seq, r.send_seq, r.pid_value, r.info_length,
                     r.dest_ssid, r.src_ssid);
  endfunction

  task automatic note_failure(input string detail);
    failures++;
    if (failures <= MAX_REPORTS) $display("%0t: %s", $time, detail);
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: offer queued bytes, idle at random, predict on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    frame_byte_t next_byte;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) absorb_byte(data_byte, last_byte);
      // hold an unaccepted byte; otherwise offer the next one or idle
      if (!byte_valid || byte_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          byte_valid <= 1'b1;
          data_byte <= next_byte.data;
          last_byte <= next_byte.last;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps going meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted item with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got.result_kind = result_kind;
        got.addr_char = addr_char;
        got.char_index = char_index;
        got.frame_kind = frame_kind;
        got.cmd_res = cmd_res;
        got.poll_final = poll_final;
        got.recv_seq = recv_seq;
        got.send_seq = send_seq;
        got.pid_value = pid_value;
        got.info_length = info_length;
        got.dest_ssid = dest_ssid;
        got.src_ssid = src_ssid;
        if (expected_results.size() == 0) begin
          note_failure({"unexpected item: ", show_result(got)});
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind || got.addr_char !== want.addr_char ||
              got.char_index !== want.char_index || got.frame_kind !== want.frame_kind ||
              got.cmd_res !== want.cmd_res || got.poll_final !== want.poll_final ||
              got.recv_seq !== want.recv_seq || got.send_seq !== want.send_seq ||
              got.pid_value !== want.pid_value || got.info_length !== want.info_length ||
              got.dest_ssid !== want.dest_ssid || got.src_ssid !== want.src_ssid) begin
            note_failure({"mismatch: expected ", show_result(want),
                          " got ", show_result(got)});
          end
        end
      end
      result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Give up if the run stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ax25_header_decoder] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle; the register loads at its end.
  task automatic write_register(input logic [ahd_pkg::PADDR_BITS-1:0] addr,
                                input logic [11:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= ahd_pkg::PDATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_length_bounds(input logic [11:0] min_len, input logic [11:0] max_len);
    write_register(ADDR_MIN_LENGTH, min_len);
    cfg_min_length = min_len;
    write_register(ADDR_MAX_LENGTH, max_len);
    cfg_max_length = max_len;
  endtask

  // Wait until every byte is taken and every item has come back, then let
  // bytes that give no item settle inside the decoder.
  task automatic wait_for_drain();
    while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_control();
    logic [7:0] r;
    logic [7:0] u_codes[6];
    r = 8'($urandom);
    u_codes = '{ahd_pkg::CTL_SABM, ahd_pkg::CTL_DISC, ahd_pkg::CTL_DM,
                ahd_pkg::CTL_UA, ahd_pkg::CTL_FRMR, ahd_pkg::CTL_UI};
    case ($urandom_range(7))
      0:       return {r[7:1], 1'b0};                      // I frame
      1:       return {r[7:2], 2'b01};                     // S frame
      2, 3, 4: return u_codes[$urandom_range(5)] | {3'b000, r[4], 4'b0000};
      5:       return r[0] ? ahd_pkg::CTL_UI : ahd_pkg::CTL_UI_PF;
      6:       return {r[7:2], 2'b11};                     // mostly unnamed U frames
      default: return r;
    endcase
  endfunction

  function automatic logic [7:0] random_pid();
    case ($urandom_range(3))
      0:       return 8'hf0;
      1:       return ahd_pkg::PID_ESCAPE;
      2:       return 8'hcf;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one frame: random address characters and payload, given header bytes.
  task automatic queue_frame(input int len, input logic [7:0] ctl, input logic [7:0] pid,
                             input logic [7:0] dssid, input logic [7:0] sssid);
    frame_byte_t fb;
    int k;
    for (k = 0; k < len; k++) begin
      if (k == ahd_pkg::POS_DEST_SSID) fb.data = dssid;
      else if (k == ahd_pkg::POS_SRC_SSID) fb.data = sssid;
      else if (k == ahd_pkg::POS_CONTROL) fb.data = ctl;
      else if (k == ahd_pkg::POS_PID) fb.data = pid;
      else fb.data = 8'($urandom);
      fb.last = (k == len - 1);
      pending_bytes.push_back(fb);
    end
  endtask

  // Mostly well-formed frames, some cut short, some longer, some right at the
  // configured length bounds.
  task automatic queue_random_frames(input int byte_budget);
    int queued;
    int len;
    int pick;
    queued = 0;
    while (queued < byte_budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = ($urandom_range(1) != 0) ? int'(cfg_min_length) : int'(cfg_max_length);
        len = len + int'($urandom_range(2)) - 1;
        if (len < 1) len = 1;
        if (len > 300) len = 300;
      end else if (pick < 20) begin
        len = $urandom_range(15, 1);
      end else if (pick < 28) begin
        len = $urandom_range(160, 49);
      end else begin
        len = $urandom_range(48, 16);
      end
      queue_frame(len, random_control(), random_pid(), 8'($urandom), 8'($urandom));
      queued += len;
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 15;
    recv_idle_pct = 83;

    // Directed, reset bounds: single-byte frames give a character and a bad
    // summary; the I frame carries top sequence numbers, P set, the PID escape
    // and a length that leaves no information bytes.
    pending_bytes.push_back(frame_byte_t'{8'h00, 1'b1});
    queue_frame(17, 8'hfe, ahd_pkg::PID_ESCAPE, 8'he0, 8'h7f);
    pending_bytes.push_back(frame_byte_t'{8'hff, 1'b1});
    queue_random_frames(250);
    wait_for_drain();

    // widest bounds: short frames now decode with missing header bytes as zero
    set_length_bounds(12'd1, 12'd4095);
    queue_random_frames(200);
    wait_for_drain();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 83;
    recv_idle_pct = 15;
    set_length_bounds(12'd20, 12'd40);
    queue_random_frames(200);
    wait_for_drain();

    // minimum above maximum: every frame is bad
    set_length_bounds(12'd4095, 12'd1);
    queue_random_frames(150);
    wait_for_drain();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_length_bounds(12'd30, 12'd30);
    queue_random_frames(150);
    wait_for_drain();

    // Hold the receiver off for a long stretch while bytes keep coming.
    set_length_bounds(12'd1, 12'd4095);
    hold_arm <= 1'b1;
    queue_random_frames(200);
    @(posedge clk);
    hold_arm <= 1'b0;
    wait_for_drain();

    if (failures == 0) begin
      $display("[ax25_header_decoder] OK");
    end else begin
      $display("[ax25_header_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ahd_pkg.sv
rtl/core/ahd_front.sv
rtl/core/ahd_queue.sv
rtl/core/ahd_back.sv
rtl/core/ax25_header_decoder.sv
dv/ax25_header_decoder_tb.sv
